// ===== hw/rtl/pm0_pkg.sv =====
// ----------------------------------------------------------------------------
// pm0_pkg
// Shared widths, default sizes, opcodes and fault codes of the stack machine.
// ----------------------------------------------------------------------------
`default_nettype none

package pm0_pkg;

  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 5;
  localparam int REG_IN_W = 4;
  localparam int LVL_W    = 2;
  localparam int FAULT_W  = 2;

  localparam int STACK_DEPTH_DEF = 2048;
  localparam int CODE_DEPTH_DEF  = 512;
  localparam int REG_COUNT_DEF   = 16;
  localparam int LEVEL_LIMIT_DEF = 3;
  localparam int PC_W_DEF        = 9;

  localparam logic [FUNC_W-1:0] OP_LIT  = 5'd0;
  localparam logic [FUNC_W-1:0] OP_RTN  = 5'd1;
  localparam logic [FUNC_W-1:0] OP_LOD  = 5'd2;
  localparam logic [FUNC_W-1:0] OP_STO  = 5'd3;
  localparam logic [FUNC_W-1:0] OP_CAL  = 5'd4;
  localparam logic [FUNC_W-1:0] OP_INC  = 5'd5;
  localparam logic [FUNC_W-1:0] OP_JMP  = 5'd6;
  localparam logic [FUNC_W-1:0] OP_JPC  = 5'd7;
  localparam logic [FUNC_W-1:0] OP_OUT  = 5'd8;
  localparam logic [FUNC_W-1:0] OP_IN   = 5'd9;
  localparam logic [FUNC_W-1:0] OP_HALT = 5'd10;
  localparam logic [FUNC_W-1:0] OP_NEG  = 5'd11;
  localparam logic [FUNC_W-1:0] OP_ADD  = 5'd12;
  localparam logic [FUNC_W-1:0] OP_SUB  = 5'd13;
  localparam logic [FUNC_W-1:0] OP_MUL  = 5'd14;
  localparam logic [FUNC_W-1:0] OP_DIV  = 5'd15;
  localparam logic [FUNC_W-1:0] OP_ODD  = 5'd16;
  localparam logic [FUNC_W-1:0] OP_MOD  = 5'd17;
  localparam logic [FUNC_W-1:0] OP_EQL  = 5'd18;
  localparam logic [FUNC_W-1:0] OP_NEQ  = 5'd19;
  localparam logic [FUNC_W-1:0] OP_LSS  = 5'd20;
  localparam logic [FUNC_W-1:0] OP_LEQ  = 5'd21;
  localparam logic [FUNC_W-1:0] OP_GTR  = 5'd22;
  localparam logic [FUNC_W-1:0] OP_GEQ  = 5'd23;

  localparam logic [FAULT_W-1:0] F_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] F_BADOP = 2'd1;
  localparam logic [FAULT_W-1:0] F_DIVZ  = 2'd2;
  localparam logic [FAULT_W-1:0] F_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/pm0_if.sv =====
// ----------------------------------------------------------------------------
// pm0_if
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface pm0_in_if;
  import pm0_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [REG_IN_W-1:0] reg_r;
  logic [LVL_W-1:0]    lex_level;
  logic [DATA_W-1:0]   operand_m;
  logic [DATA_W-1:0]   in_value;
  modport source(output valid, func, reg_r, lex_level, operand_m, in_value, input ready);
  modport sink(input valid, func, reg_r, lex_level, operand_m, in_value, output ready);
endinterface

interface pm0_out_if #(
  parameter int PC_W = pm0_pkg::PC_W_DEF
);
  import pm0_pkg::*;
  logic               valid;
  logic               ready;
  logic [PC_W-1:0]    next_pc;
  logic               out_valid;
  logic [DATA_W-1:0]  out_value;
  logic               halted;
  logic [FAULT_W-1:0] fault;
  modport source(output valid, next_pc, out_valid, out_value, halted, fault, input ready);
  modport sink(input valid, next_pc, out_valid, out_value, halted, fault, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pm0_reg_file.sv =====
// ----------------------------------------------------------------------------
// pm0_reg_file
// Data register memory, two registered read ports, one write port, valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pm0_reg_file #(
  parameter int REG_COUNT = pm0_pkg::REG_COUNT_DEF,
  parameter int RW = $clog2(REG_COUNT)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [RW-1:0]             ra,
  input  logic [RW-1:0]             rb,
  output logic [pm0_pkg::DATA_W-1:0] rda,
  output logic [pm0_pkg::DATA_W-1:0] rdb,
  input  logic                      we,
  input  logic [RW-1:0]             wa,
  input  logic [pm0_pkg::DATA_W-1:0] wd
);
  import pm0_pkg::*;

  logic [DATA_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [DATA_W-1:0]    qa_r, qb_r;
  logic                 va_r, vb_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      qa_r <= mem[ra];
      qb_r <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      if (rd_en) begin
        va_r <= vld_r[ra];
        vb_r <= vld_r[rb];
      end
    end
  end

  assign rda = va_r ? qa_r : '0;
  assign rdb = vb_r ? qb_r : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/pm0_stack_ram.sv =====
// ----------------------------------------------------------------------------
// pm0_stack_ram
// Stack memory with registered read and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pm0_stack_ram #(
  parameter int DEPTH = pm0_pkg::STACK_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [pm0_pkg::DATA_W-1:0] rd_data,
  input  logic                       we,
  input  logic [AW-1:0]              wa,
  input  logic [pm0_pkg::DATA_W-1:0] wd,
  output logic                       clearing
);
  import pm0_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic              clr_r;
  logic [AW-1:0]     cptr_r;
  logic              mwe;
  logic [AW-1:0]     mwa;
  logic [DATA_W-1:0] mwd;

  always_comb begin
    mwe = we;
    mwa = wa;
    mwd = wd;
    if (clr_r) begin
      mwe = 1'b1;
      mwa = cptr_r;
      mwd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[mwa] <= mwd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= 1'b1;
      cptr_r <= '0;
    end else if (clr_r) begin
      cptr_r <= cptr_r + AW'(1);
      if (cptr_r == AW'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign clearing = clr_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pm0_divider.sv =====
// ----------------------------------------------------------------------------
// pm0_divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pm0_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pm0_pkg::DATA_W-1:0] num,
  input  logic [pm0_pkg::DATA_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [pm0_pkg::DATA_W-1:0] quo,
  output logic [pm0_pkg::DATA_W-1:0] rem
);
  import pm0_pkg::*;

  localparam int CW = $clog2(DATA_W);

  logic              busy_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [DATA_W-1:0] quo_r, rem_r, den_r;
  logic [DATA_W:0]   sh, diff;

  assign sh   = {rem_r, quo_r[DATA_W-1]};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pm0_register_stack_machine.sv =====
// ----------------------------------------------------------------------------
// pm0_register_stack_machine
// Register-variant stack machine executing one decoded instruction per beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   func reg_r lex_level operand_m in_value
//  out_ch   out  valid/ready   next_pc out_valid out_value halted fault
//
//  one instruction at a time: register, alu, out and halt ops pass S_RD,
//  S_EXEC and S_DONE; taken jumps add S_PC, lod/sto the walk per static link,
//  rtn S_RTN1/S_RTN2, cal S_CAL; S_KMOD/S_PCMOD fold an alu register index
//  or a pc target beyond its range; div/mod wait in S_DIV for the serial divider.
//  after reset the stack memory is zeroed entry by entry; in_ch is
//  not ready meanwhile. a waiting result holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pm0_register_stack_machine #(
  parameter int STACK_DEPTH = pm0_pkg::STACK_DEPTH_DEF,
  parameter int CODE_DEPTH  = pm0_pkg::CODE_DEPTH_DEF,
  parameter int REG_COUNT   = pm0_pkg::REG_COUNT_DEF,
  parameter int LEVEL_LIMIT = pm0_pkg::LEVEL_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pm0_in_if.sink    in_ch,
  pm0_out_if.source out_ch
);
  import pm0_pkg::*;

  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int PCW = $clog2(CODE_DEPTH);
  localparam int RW  = $clog2(REG_COUNT);
  localparam int LCW = $clog2(LEVEL_LIMIT + 1);
  localparam int MSW = 22;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KMOD  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_WALKW = 4'd6;
  localparam logic [3:0] S_LODW  = 4'd7;
  localparam logic [3:0] S_CAL   = 4'd8;
  localparam logic [3:0] S_RTN1  = 4'd9;
  localparam logic [3:0] S_RTN2  = 4'd10;
  localparam logic [3:0] S_PC    = 4'd11;
  localparam logic [3:0] S_PCMOD = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  function automatic logic [RW-1:0] reg_mod(input logic [REG_IN_W-1:0] v);
    logic [6:0] t;
    t = 7'(v);
    for (int i = 0; i < 8; i++) begin
      if (t >= 7'(REG_COUNT)) begin
        t = t - 7'(REG_COUNT);
      end
    end
    return t[RW-1:0];
  endfunction

  // sum of the set bits weighted by their power of two modulo n, as a tree
  function automatic logic [MSW-1:0] fold_sum(input logic [DATA_W-1:0] v,
                                               input int n);
    logic [MSW-1:0] t [DATA_W];
    logic [MSW-1:0] w;
    w = MSW'(1);
    for (int i = 0; i < DATA_W; i++) begin
      t[i] = v[i] ? w : '0;
      w = w << 1;
      if (w >= MSW'(n)) begin
        w = w - MSW'(n);
      end
    end
    for (int step = 1; step < DATA_W; step = step * 2) begin
      for (int i = 0; i < DATA_W; i = i + 2 * step) begin
        t[i] = t[i] + t[i + step];
      end
    end
    return t[0];
  endfunction

  // folded sum is below 32 n, so five compare and subtract steps finish it
  function automatic logic [MSW-1:0] fold_reduce(input logic [MSW-1:0] s,
                                                  input int n);
    logic [MSW-1:0] r;
    r = s;
    for (int k = 4; k >= 0; k--) begin
      if (r >= MSW'(n << k)) begin
        r = r - MSW'(n << k);
      end
    end
    return r;
  endfunction

  function automatic logic [33:0] sx(input logic [DATA_W-1:0] v);
    return {{2{v[DATA_W-1]}}, v};
  endfunction

  function automatic logic in_rng(input logic [33:0] v);
    return !v[33] && (v[32:0] < 33'(STACK_DEPTH));
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic [PCW-1:0]     pc_r, pc_nxt;
  logic [SW-1:0]      bp_r, bp_nxt, sp_r, sp_nxt, wb_r, wb_nxt;
  logic               stopped_r, stopped_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [RW-1:0]      ri_r, ri_nxt, ra_r, ra_nxt, rb_r, rb_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [DATA_W-1:0]  m_r, m_nxt, inval_r, inval_nxt, tgt_r, tgt_nxt;
  logic [LCW-1:0]     wcnt_r, wcnt_nxt;
  logic [1:0]         ccnt_r, ccnt_nxt;
  logic               ov_r, ov_nxt;
  logic [DATA_W-1:0]  oval_r, oval_nxt;
  logic [FAULT_W-1:0] fault_r, fault_nxt;
  logic [MSW-1:0]     msum_r, msum_nxt;

  logic               ovr_r, ovr_nxt;
  logic [PCW-1:0]     o_pc_r, o_pc_nxt;
  logic               o_ov_r, o_ov_nxt, o_halt_r, o_halt_nxt;
  logic [DATA_W-1:0]  o_oval_r, o_oval_nxt;
  logic [FAULT_W-1:0] o_fault_r, o_fault_nxt;

  logic               rf_rd_en, rf_we;
  logic [RW-1:0]      rf_ra, rf_rb, rf_wa;
  logic [DATA_W-1:0]  rf_rda, rf_rdb, rf_wd;
  logic               sk_rd_en, sk_we, sk_clearing;
  logic [SW-1:0]      sk_rd_addr, sk_wa;
  logic [DATA_W-1:0]  sk_rd_data, sk_wd;
  logic               div_start, div_busy, div_done;
  logic [DATA_W-1:0]  div_num, div_den, div_quo, div_rem;

  logic               acc, in_alu;
  logic [PCW:0]       pinc;
  logic [33:0]        idx;
  logic [DATA_W-1:0]  a, b, q_s, r_s;

  pm0_reg_file #(.REG_COUNT(REG_COUNT), .RW(RW)) u_rf (
    .clk(clk), .rst_n(rst_n), .rd_en(rf_rd_en), .ra(rf_ra), .rb(rf_rb),
    .rda(rf_rda), .rdb(rf_rdb), .we(rf_we), .wa(rf_wa), .wd(rf_wd)
  );

  pm0_stack_ram #(.DEPTH(STACK_DEPTH), .AW(SW)) u_stk (
    .clk(clk), .rst_n(rst_n), .rd_en(sk_rd_en), .rd_addr(sk_rd_addr),
    .rd_data(sk_rd_data), .we(sk_we), .wa(sk_wa), .wd(sk_wd),
    .clearing(sk_clearing)
  );

  pm0_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !sk_clearing;
  assign acc         = in_ch.valid && in_ch.ready;
  assign in_alu      = (in_ch.func >= OP_NEG) && (in_ch.func <= OP_GEQ);
  assign pinc        = {1'b0, pc_r} + (PCW + 1)'(1);
  assign a           = rf_rda;
  assign b           = rf_rdb;
  assign q_s         = (a[DATA_W-1] ^ b[DATA_W-1]) ? (DATA_W'(0) - div_quo) : div_quo;
  assign r_s         = a[DATA_W-1] ? (DATA_W'(0) - div_rem) : div_rem;
  assign idx         = (func_r == OP_INC) ? (34'(sp_r) + sx(m_r)) : (34'(wb_r) + sx(m_r));

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    bp_nxt      = bp_r;
    sp_nxt      = sp_r;
    wb_nxt      = wb_r;
    stopped_nxt = stopped_r;
    func_nxt    = func_r;
    ri_nxt      = ri_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    lvl_nxt     = lvl_r;
    m_nxt       = m_r;
    inval_nxt   = inval_r;
    tgt_nxt     = tgt_r;
    wcnt_nxt    = wcnt_r;
    ccnt_nxt    = ccnt_r;
    ov_nxt      = ov_r;
    oval_nxt    = oval_r;
    fault_nxt   = fault_r;
    msum_nxt    = msum_r;
    ovr_nxt     = ovr_r && !out_ch.ready;
    o_pc_nxt    = o_pc_r;
    o_ov_nxt    = o_ov_r;
    o_oval_nxt  = o_oval_r;
    o_halt_nxt  = o_halt_r;
    o_fault_nxt = o_fault_r;
    rf_rd_en    = 1'b0;
    rf_ra       = ra_r;
    rf_rb       = rb_r;
    rf_we       = 1'b0;
    rf_wa       = ri_r;
    rf_wd       = '0;
    sk_rd_en    = 1'b0;
    sk_rd_addr  = '0;
    sk_we       = 1'b0;
    sk_wa       = '0;
    sk_wd       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          func_nxt  = in_ch.func;
          ri_nxt    = reg_mod(in_ch.reg_r);
          lvl_nxt   = in_ch.lex_level;
          m_nxt     = in_ch.operand_m;
          inval_nxt = in_ch.in_value;
          ra_nxt    = (in_alu && in_ch.func != OP_NEG) ? reg_mod(REG_IN_W'(in_ch.lex_level))
                                                       : reg_mod(in_ch.reg_r);
          rb_nxt    = in_ch.operand_m[RW-1:0];
          ov_nxt    = 1'b0;
          oval_nxt  = '0;
          fault_nxt = F_NONE;
          if (stopped_r || bp_r == '0) begin
            stopped_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            pc_nxt = (pinc == (PCW + 1)'(CODE_DEPTH)) ? '0 : pinc[PCW-1:0];
            if (in_alu && in_ch.operand_m >= DATA_W'(REG_COUNT)) begin
              msum_nxt  = fold_sum(in_ch.operand_m, REG_COUNT);
              state_nxt = S_KMOD;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_KMOD: begin
        rb_nxt    = RW'(fold_reduce(msum_r, REG_COUNT));
        state_nxt = S_RD;
      end
      S_RD: begin
        rf_rd_en  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        rf_wa     = ri_r;
        unique case (func_r) inside
          OP_LIT: begin
            rf_we = 1'b1;
            rf_wd = m_r;
          end
          OP_IN: begin
            rf_we = 1'b1;
            rf_wd = inval_r;
          end
          OP_OUT: begin
            ov_nxt   = 1'b1;
            oval_nxt = a;
          end
          OP_HALT: stopped_nxt = 1'b1;
          OP_JMP: begin
            tgt_nxt   = m_r;
            state_nxt = S_PC;
          end
          OP_JPC: begin
            if (a == '0) begin
              tgt_nxt   = m_r;
              state_nxt = S_PC;
            end
          end
          OP_INC: begin
            if (in_rng(idx)) begin
              sp_nxt = idx[SW-1:0];
            end else begin
              fault_nxt   = F_RANGE;
              stopped_nxt = 1'b1;
            end
          end
          OP_RTN: begin
            if (in_rng(34'(bp_r) + 34'd3)) begin
              sk_rd_en   = 1'b1;
              sk_rd_addr = bp_r + SW'(2);
              state_nxt  = S_RTN1;
            end else begin
              fault_nxt   = F_RANGE;
              stopped_nxt = 1'b1;
            end
          end
          OP_LOD, OP_STO, OP_CAL: begin
            wb_nxt   = bp_r;
            wcnt_nxt = LCW'((int'(lvl_r) > LEVEL_LIMIT) ? LEVEL_LIMIT : int'(lvl_r));
            if (func_r == OP_CAL && !in_rng(34'(sp_r) + 34'd4)) begin
              fault_nxt   = F_RANGE;
              stopped_nxt = 1'b1;
            end else begin
              state_nxt = S_WALK;
            end
          end
          OP_NEG: begin
            rf_we = 1'b1;
            rf_wd = DATA_W'(0) - a;
          end
          OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = a + b;
          end
          OP_SUB: begin
            rf_we = 1'b1;
            rf_wd = a - b;
          end
          OP_MUL: begin
            rf_we = 1'b1;
            rf_wd = a * b;
          end
          OP_ODD: begin
            rf_we = 1'b1;
            rf_wd = a[0] ? (a[DATA_W-1] ? '1 : DATA_W'(1)) : '0;
          end
          OP_DIV, OP_MOD: begin
            if (b == '0) begin
              rf_we       = 1'b1;
              rf_wd       = '0;
              fault_nxt   = F_DIVZ;
              stopped_nxt = 1'b1;
            end else begin
              div_start = 1'b1;
              div_num   = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
              div_den   = b[DATA_W-1] ? (DATA_W'(0) - b) : b;
              state_nxt = S_DIV;
            end
          end
          OP_EQL: begin
            rf_we = 1'b1;
            rf_wd = DATA_W'(a == b);
          end
          OP_NEQ: begin
            rf_we = 1'b1;
            rf_wd = DATA_W'(a != b);
          end
          OP_LSS: begin
            rf_we = 1'b1;
            rf_wd = DATA_W'($signed(a) < $signed(b));
          end
          OP_LEQ: begin
            rf_we = 1'b1;
            rf_wd = DATA_W'($signed(a) <= $signed(b));
          end
          OP_GTR: begin
            rf_we = 1'b1;
            rf_wd = DATA_W'($signed(a) > $signed(b));
          end
          OP_GEQ: begin
            rf_we = 1'b1;
            rf_wd = DATA_W'($signed(a) >= $signed(b));
          end
          default: begin
            fault_nxt   = F_BADOP;
            stopped_nxt = 1'b1;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          rf_we     = 1'b1;
          rf_wd     = (func_r == OP_DIV) ? q_s : r_s;
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        if (wcnt_r == '0) begin
          if (func_r == OP_CAL) begin
            ccnt_nxt  = '0;
            state_nxt = S_CAL;
          end else if (!in_rng(idx)) begin
            fault_nxt   = F_RANGE;
            stopped_nxt = 1'b1;
            state_nxt   = S_DONE;
          end else if (func_r == OP_LOD) begin
            sk_rd_en   = 1'b1;
            sk_rd_addr = idx[SW-1:0];
            state_nxt  = S_LODW;
          end else begin
            sk_we     = 1'b1;
            sk_wa     = idx[SW-1:0];
            sk_wd     = a;
            state_nxt = S_DONE;
          end
        end else if (in_rng(34'(wb_r) + 34'd1)) begin
          sk_rd_en   = 1'b1;
          sk_rd_addr = wb_r + SW'(1);
          state_nxt  = S_WALKW;
        end else begin
          fault_nxt   = F_RANGE;
          stopped_nxt = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_WALKW: begin
        if (in_rng(sx(sk_rd_data))) begin
          wb_nxt    = sk_rd_data[SW-1:0];
          wcnt_nxt  = wcnt_r - LCW'(1);
          state_nxt = S_WALK;
        end else begin
          fault_nxt   = F_RANGE;
          stopped_nxt = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_LODW: begin
        rf_we     = 1'b1;
        rf_wd     = sk_rd_data;
        state_nxt = S_DONE;
      end
      S_CAL: begin
        sk_we    = 1'b1;
        sk_wa    = sp_r + SW'(ccnt_r) + SW'(1);
        ccnt_nxt = ccnt_r + 2'd1;
        case (ccnt_r)
          2'd0:    sk_wd = '0;
          2'd1:    sk_wd = DATA_W'(wb_r);
          2'd2:    sk_wd = DATA_W'(bp_r);
          default: sk_wd = DATA_W'(pc_r);
        endcase
        if (ccnt_r == 2'd3) begin
          bp_nxt    = sp_r + SW'(1);
          tgt_nxt   = m_r;
          state_nxt = S_PC;
        end
      end
      S_RTN1: begin
        if (in_rng(sx(sk_rd_data))) begin
          wb_nxt     = sk_rd_data[SW-1:0];
          sk_rd_en   = 1'b1;
          sk_rd_addr = bp_r + SW'(3);
          state_nxt  = S_RTN2;
        end else begin
          fault_nxt   = F_RANGE;
          stopped_nxt = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_RTN2: begin
        sp_nxt    = bp_r - SW'(1);
        bp_nxt    = wb_r;
        tgt_nxt   = sk_rd_data;
        state_nxt = S_PC;
        if (wb_r == '0) begin
          stopped_nxt = 1'b1;
        end
      end
      S_PC: begin
        if (tgt_r < DATA_W'(CODE_DEPTH)) begin
          pc_nxt    = tgt_r[PCW-1:0];
          state_nxt = S_DONE;
        end else begin
          msum_nxt  = fold_sum(tgt_r, CODE_DEPTH);
          state_nxt = S_PCMOD;
        end
      end
      S_PCMOD: begin
        pc_nxt    = PCW'(fold_reduce(msum_r, CODE_DEPTH));
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovr_r || out_ch.ready) begin
          ovr_nxt     = 1'b1;
          o_pc_nxt    = pc_r;
          o_ov_nxt    = ov_r;
          o_oval_nxt  = oval_r;
          o_halt_nxt  = stopped_r;
          o_fault_nxt = fault_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pc_r      <= '0;
      bp_r      <= SW'(1);
      sp_r      <= '0;
      stopped_r <= 1'b0;
      ovr_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= pc_nxt;
      bp_r      <= bp_nxt;
      sp_r      <= sp_nxt;
      stopped_r <= stopped_nxt;
      ovr_r     <= ovr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    ri_r      <= ri_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    lvl_r     <= lvl_nxt;
    m_r       <= m_nxt;
    inval_r   <= inval_nxt;
    tgt_r     <= tgt_nxt;
    wb_r      <= wb_nxt;
    wcnt_r    <= wcnt_nxt;
    ccnt_r    <= ccnt_nxt;
    ov_r      <= ov_nxt;
    oval_r    <= oval_nxt;
    fault_r   <= fault_nxt;
    msum_r    <= msum_nxt;
    o_pc_r    <= o_pc_nxt;
    o_ov_r    <= o_ov_nxt;
    o_oval_r  <= o_oval_nxt;
    o_halt_r  <= o_halt_nxt;
    o_fault_r <= o_fault_nxt;
  end

  assign out_ch.valid     = ovr_r;
  assign out_ch.next_pc   = o_pc_r;
  assign out_ch.out_valid = o_ov_r;
  assign out_ch.out_value = o_oval_r;
  assign out_ch.halted    = o_halt_r;
  assign out_ch.fault     = o_fault_r;

  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !sk_clearing)
    else $error("instruction beat taken during stack clear");

  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.fault != F_NONE) |-> out_ch.halted)
    else $error("fault reported without halt");

  a_print_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_valid) |-> (out_ch.fault == F_NONE))
    else $error("printed value together with a fault");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second beat taken before the first finished");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives decoded PM/0 instructions into the register stack machine and checks
// every result beat against a cycle-free model of the machine state. Random
// programs avoid stopping the machine until the very end, where a single
// halting instruction is issued and the following beats are checked as ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pm0_pkg::*;

  localparam int STACK_N   = STACK_DEPTH_DEF;
  localparam int N_RANDOM  = 1520;
  localparam int LIMIT     = 600000;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [REG_IN_W-1:0] reg_r;
    logic [LVL_W-1:0]    lex_level;
    logic [DATA_W-1:0]   operand_m;
    logic [DATA_W-1:0]   in_value;
  } instr_t;

  typedef struct packed {
    logic [PC_W_DEF-1:0] next_pc;
    logic                out_valid;
    logic [DATA_W-1:0]   out_value;
    logic                halted;
    logic [FAULT_W-1:0]  fault;
  } result_t;

  class machine_scoreboard;
    bit [31:0] regs[16];
    bit [31:0] stack[STACK_N];
    bit [8:0]  pc;
    bit [10:0] bp;
    bit [10:0] sp;
    bit        stopped;
    result_t   expected_q[$];
    int        errors;
    int        checked;
    int        printed;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (stack[i]) stack[i] = '0;
      pc = '0;
      bp = 11'd1;
      sp = '0;
      stopped = 1'b0;
      errors = 0;
      checked = 0;
      printed = 0;
    endfunction

    function bit in_range(longint i);
      return i >= 0 && i < STACK_N;
    endfunction

    function longint sx(bit [31:0] v);
      return longint'($signed(v));
    endfunction

    function bit walk_links(bit [1:0] lvl, output longint b);
      b = longint'(bp);
      for (int n = 0; n < lvl; n++) begin
        if (!in_range(b + 1)) return 1'b0;
        b = sx(stack[b + 1]);
        if (!in_range(b)) return 1'b0;
      end
      return 1'b1;
    endfunction

    // works out one instruction; state is only updated when apply is set
    function result_t execute(instr_t t, bit apply);
      result_t     res;
      bit [31:0]   ua, ub, v, nb, np, rval, oval;
      bit [31:0]   sw_val[4];
      longint      a, c, ms, idx, b;
      longint      sw_idx[4];
      bit [8:0]    npc;
      bit [10:0]   nbp, nsp;
      bit          nstop, rwe, ovalid;
      bit [1:0]    flt;
      int          nsw;
      npc = pc;
      nbp = bp;
      nsp = sp;
      nstop = stopped;
      flt = F_NONE;
      rwe = 1'b0;
      rval = '0;
      nsw = 0;
      ovalid = 1'b0;
      oval = '0;
      v = '0;
      b = 0;
      ms = sx(t.operand_m);
      if (!stopped && bp != 0) begin
        npc = pc + 9'd1;
        if (t.func >= OP_NEG && t.func <= OP_GEQ) begin
          ua = regs[t.lex_level];
          ub = regs[t.operand_m[3:0]];
          a = sx(ua);
          c = sx(ub);
          case (t.func)
            OP_NEG: v = 32'd0 - regs[t.reg_r];
            OP_ADD: v = ua + ub;
            OP_SUB: v = ua - ub;
            OP_MUL: v = ua * ub;
            OP_DIV: if (c == 0) flt = F_DIVZ; else v = 32'(a / c);
            OP_ODD: v = 32'(a % 2);
            OP_MOD: if (c == 0) flt = F_DIVZ; else v = 32'(a % c);
            OP_EQL: v = 32'(a == c);
            OP_NEQ: v = 32'(a != c);
            OP_LSS: v = 32'(a < c);
            OP_LEQ: v = 32'(a <= c);
            OP_GTR: v = 32'(a > c);
            default: v = 32'(a >= c);
          endcase
          rwe = 1'b1;
          rval = v;
        end else begin
          case (t.func)
            OP_LIT: begin
              rwe = 1'b1;
              rval = t.operand_m;
            end
            OP_RTN: begin
              if (!in_range(longint'(bp) + 3) || !in_range(sx(stack[longint'(bp) + 2]))) begin
                flt = F_RANGE;
              end else begin
                nb = stack[longint'(bp) + 2];
                np = stack[longint'(bp) + 3];
                nsp = bp - 11'd1;
                nbp = nb[10:0];
                npc = np[8:0];
                if (nbp == 0) nstop = 1'b1;
              end
            end
            OP_LOD, OP_STO: begin
              if (!walk_links(t.lex_level, b)) begin
                flt = F_RANGE;
              end else begin
                idx = b + ms;
                if (!in_range(idx)) begin
                  flt = F_RANGE;
                end else if (t.func == OP_LOD) begin
                  rwe = 1'b1;
                  rval = stack[idx];
                end else begin
                  sw_idx[0] = idx;
                  sw_val[0] = regs[t.reg_r];
                  nsw = 1;
                end
              end
            end
            OP_CAL: begin
              if (!in_range(longint'(sp) + 4) || !walk_links(t.lex_level, b)) begin
                flt = F_RANGE;
              end else begin
                sw_idx[0] = longint'(sp) + 1; sw_val[0] = '0;
                sw_idx[1] = longint'(sp) + 2; sw_val[1] = 32'(b);
                sw_idx[2] = longint'(sp) + 3; sw_val[2] = 32'(bp);
                sw_idx[3] = longint'(sp) + 4; sw_val[3] = 32'(npc);
                nsw = 4;
                nbp = sp + 11'd1;
                npc = t.operand_m[8:0];
              end
            end
            OP_INC: begin
              idx = longint'(sp) + ms;
              if (!in_range(idx)) flt = F_RANGE;
              else nsp = idx[10:0];
            end
            OP_JMP: npc = t.operand_m[8:0];
            OP_JPC: if (regs[t.reg_r] == 0) npc = t.operand_m[8:0];
            OP_OUT: begin
              ovalid = 1'b1;
              oval = regs[t.reg_r];
            end
            OP_IN: begin
              rwe = 1'b1;
              rval = t.in_value;
            end
            OP_HALT: nstop = 1'b1;
            default: flt = F_BADOP;
          endcase
        end
        if (flt != F_NONE) nstop = 1'b1;
      end else begin
        nstop = 1'b1;
      end
      res.next_pc = npc;
      res.out_valid = ovalid;
      res.out_value = oval;
      res.halted = nstop;
      res.fault = flt;
      if (apply) begin
        pc = npc;
        bp = nbp;
        sp = nsp;
        stopped = nstop;
        if (rwe) regs[t.reg_r] = rval;
        for (int i = 0; i < nsw; i++) stack[sw_idx[i]] = sw_val[i];
      end
      return res;
    endfunction

    function void note_instr(instr_t t);
      expected_q.push_back(execute(t, 1'b1));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.out_valid) printed++;
      if (got.next_pc !== want.next_pc) begin
        $error("next_pc expected %0d actual %0d", want.next_pc, got.next_pc);
        errors++;
      end
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid expected %0d actual %0d", want.out_valid, got.out_valid);
        errors++;
      end
      if (got.out_value !== want.out_value) begin
        $error("out_value expected %0h actual %0h", want.out_value, got.out_value);
        errors++;
      end
      if (got.halted !== want.halted) begin
        $error("halted expected %0d actual %0d", want.halted, got.halted);
        errors++;
      end
      if (got.fault !== want.fault) begin
        $error("fault expected %0d actual %0d", want.fault, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  bit   quiet;
  int   ready_gap;
  int   calls;

  machine_scoreboard sb;

  pm0_in_if  in_ch();
  pm0_out_if out_ch();

  pm0_register_stack_machine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check the beat, then decide on stalls
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.next_pc, out_ch.out_valid, out_ch.out_value,
                       out_ch.halted, out_ch.fault});
    if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      ready_gap <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_instr(instr_t t);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= t.func;
    in_ch.reg_r     <= t.reg_r;
    in_ch.lex_level <= t.lex_level;
    in_ch.operand_m <= t.operand_m;
    in_ch.in_value  <= t.in_value;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_instr(t);
    if (t.func == OP_CAL) calls++;
  endtask

  task automatic send_op(logic [FUNC_W-1:0] f, int r, int lvl, logic [31:0] m);
    instr_t t;
    t.func = f;
    t.reg_r = r[3:0];
    t.lex_level = lvl[1:0];
    t.operand_m = m;
    t.in_value = $urandom();
    send_instr(t);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // random instruction that keeps the machine running
  function automatic instr_t pick_instr();
    instr_t t;
    result_t r;
    int sel;
    for (int tries = 0; tries < 30; tries++) begin
      t.reg_r = 4'($urandom());
      t.lex_level = 2'($urandom());
      t.operand_m = $urandom();
      t.in_value = $urandom();
      sel = $urandom_range(0, 99);
      if (sel < 14) t.func = OP_LIT;
      else if (sel < 44) t.func = FUNC_W'($urandom_range(OP_NEG, OP_GEQ));
      else if (sel < 56) t.func = OP_LOD;
      else if (sel < 66) t.func = OP_STO;
      else if (sel < 73) t.func = OP_CAL;
      else if (sel < 80) t.func = OP_RTN;
      else if (sel < 86) t.func = OP_INC;
      else if (sel < 89) t.func = OP_JMP;
      else if (sel < 93) t.func = OP_JPC;
      else if (sel < 97) t.func = OP_OUT;
      else t.func = OP_IN;
      if (t.func == OP_LIT && $urandom_range(0, 1)) t.operand_m = $urandom_range(0, 9) - 4;
      if (t.func == OP_LOD || t.func == OP_STO) t.operand_m = $urandom_range(0, 16) - 4;
      if (t.func == OP_INC) t.operand_m = $urandom_range(0, 14) - 5;
      r = sb.execute(t, 1'b0);
      if (!r.halted) return t;
    end
    t.func = OP_LIT;
    return t;
  endfunction

  initial begin
    instr_t t;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    quiet = 1'b0;
    ready_gap = 0;
    calls = 0;
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.reg_r = '0;
    in_ch.lex_level = '0;
    in_ch.operand_m = '0;
    in_ch.in_value = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, overflow, every non-halting operation
    send_op(OP_LIT, 0, 0, 32'h8000_0000);
    send_op(OP_LIT, 1, 0, 32'hFFFF_FFFF);
    send_op(OP_DIV, 2, 0, 32'd1);
    send_op(OP_MOD, 3, 0, 32'd1);
    send_op(OP_ODD, 4, 1, 32'd0);
    send_op(OP_NEG, 0, 0, 32'd0);
    for (int f = OP_ADD; f <= OP_GEQ; f++)
      if (f != OP_DIV && f != OP_MOD && f != OP_ODD) send_op(FUNC_W'(f), 5, 0, 32'd1);
    send_op(OP_OUT, 15, 0, 32'd0);
    t = '{func: OP_IN, reg_r: 4'd14, lex_level: 2'd0, operand_m: 32'd0,
          in_value: 32'h7FFF_FFFF};
    send_instr(t);
    send_op(OP_OUT, 14, 0, 32'd0);
    send_op(OP_JPC, 15, 0, 32'd300);
    send_op(OP_JMP, 0, 0, 32'hFFFF_FFFF);
    send_op(OP_INC, 0, 0, 32'd5);
    send_op(OP_STO, 1, 0, 32'd4);
    send_op(OP_CAL, 0, 1, 32'd100);
    send_op(OP_LOD, 13, 3, 32'd5);
    send_op(OP_RTN, 0, 0, 32'd0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain();
      if (i == N_RANDOM - 150) quiet = 1'b1;
      send_instr(pick_instr());
    end

    // one stopping instruction, then beats that must be ignored
    t = pick_instr();
    case ($urandom_range(0, 3))
      0: t.func = FUNC_W'($urandom_range(24, 31));
      1: t.func = OP_HALT;
      2: begin
        t.func = OP_INC;
        t.operand_m = 32'h8000_0000;
      end
      default: begin
        send_op(OP_LIT, 7, 0, 32'd0);
        t.func = OP_DIV;
        t.operand_m = 32'd7;
      end
    endcase
    send_instr(t);
    t.func = 5'd31;
    send_instr(t);
    for (int i = 0; i < 6; i++) send_instr(pick_instr());

    drain();
    repeat (60) @(posedge clk);
    $display("%0d result beats checked, %0d printed values, %0d calls taken",
             sb.checked, sb.printed, calls);
    $display("machine stopped: %0d, leftover expectations: %0d",
             sb.stopped, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pm0_pkg.sv
hw/rtl/pm0_if.sv
hw/rtl/pm0_reg_file.sv
hw/rtl/pm0_stack_ram.sv
hw/rtl/pm0_divider.sv
hw/rtl/pm0_register_stack_machine.sv
test/testbench.sv
